@@ rtl/core/sha1sh_pkg.sv @@
// Shared types and constants for the SHA-1 stream hasher.
// Used by sha1sh_ctrl, sha1sh_dp and sha1_stream_hasher_unit; no dependencies.
package sha1sh_pkg;

   // input action codes (req_tuser)
   localparam logic ACT_ABSORB = 1'b0;
   localparam logic ACT_FINISH = 1'b1;

   // source of the byte pushed into the block buffer
   localparam logic [1:0] SRC_DATA = 2'd0;
   localparam logic [1:0] SRC_PAD  = 2'd1;
   localparam logic [1:0] SRC_ZERO = 2'd2;
   localparam logic [1:0] SRC_LEN  = 2'd3;

   // round function groups
   localparam logic [1:0] PH_CH   = 2'd0;
   localparam logic [1:0] PH_PAR1 = 2'd1;
   localparam logic [1:0] PH_MAJ  = 2'd2;
   localparam logic [1:0] PH_PAR2 = 2'd3;

   localparam logic [31:0] K_CH   = 32'h5A827999;
   localparam logic [31:0] K_PAR1 = 32'h6ED9EBA1;
   localparam logic [31:0] K_MAJ  = 32'h8F1BBCDC;
   localparam logic [31:0] K_PAR2 = 32'hCA62C1D6;

   localparam logic [7:0] PAD_BYTE = 8'h80;
   localparam logic [5:0] LEN_START = 6'd56;

   localparam int WORD_W    = 32;
   localparam int NUM_WORDS = 5;
   localparam int LEN_W     = 61;

   localparam logic [NUM_WORDS-1:0][WORD_W-1:0] INIT_CHAIN = {
      32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE, 32'hEFCDAB89, 32'h67452301
   };

   typedef struct packed {
      logic       push;       // shift one byte into the block buffer
      logic [1:0] byte_src;
      logic [2:0] len_sel;    // which length byte, most significant first
      logic       len_inc;
      logic       load_work;  // a..e <= chaining words
      logic       round;      // one compression round
      logic [1:0] phase;
      logic       fold;       // chaining words += a..e
      logic       clear;      // back to initial chaining words and zero length
      logic [2:0] word_sel;
   } sha1sh_cmd_type;

endpackage

@@ rtl/core/sha1sh_dp.sv @@
// SHA-1 datapath: block buffer / schedule window, work registers, chaining
// words and byte count. Depends on sha1sh_pkg; driven by sha1sh_ctrl.
module sha1sh_dp (
   input  logic                      clock,
   input  logic                      reset,
   input  sha1sh_pkg::sha1sh_cmd_type cmd,
   input  logic [7:0]                data_byte,
   output logic [31:0]               digest_word
);
   import sha1sh_pkg::*;

   // block buffer doubles as the 16-word schedule window; first byte on top
   logic [511:0] blk_ff, blk_in;
   logic [NUM_WORDS-1:0][WORD_W-1:0] h_ff, h_in;
   logic [WORD_W-1:0] a_ff, b_ff, c_ff, d_ff, e_ff;
   logic [WORD_W-1:0] a_in, b_in, c_in, d_in, e_in;
   logic [LEN_W-1:0]  len_ff, len_in;

   logic [63:0]       bit_len;
   logic [7:0]        len_byte;
   logic [7:0]        push_byte;
   logic [WORD_W-1:0] w_cur, w_x, w_new, f_val, k_val, t_val;

   assign bit_len  = {len_ff, 3'b000};
   assign len_byte = bit_len[{~cmd.len_sel, 3'b000} +: 8];

   always_comb begin
      case (cmd.byte_src)
         SRC_DATA: push_byte = data_byte;
         SRC_PAD:  push_byte = PAD_BYTE;
         SRC_ZERO: push_byte = 8'h00;
         SRC_LEN:  push_byte = len_byte;
         default:  push_byte = 8'h00;
      endcase
   end

   assign w_cur = blk_ff[511:480];
   assign w_x   = blk_ff[95:64] ^ blk_ff[255:224] ^ blk_ff[447:416] ^ blk_ff[511:480];
   assign w_new = {w_x[30:0], w_x[31]};

   always_comb begin
      case (cmd.phase)
         PH_CH:   begin f_val = (b_ff & c_ff) | (~b_ff & d_ff);              k_val = K_CH;   end
         PH_PAR1: begin f_val = b_ff ^ c_ff ^ d_ff;                          k_val = K_PAR1; end
         PH_MAJ:  begin
            f_val = (b_ff & c_ff) | (b_ff & d_ff) | (c_ff & d_ff);
            k_val = K_MAJ;
         end
         PH_PAR2: begin f_val = b_ff ^ c_ff ^ d_ff;                          k_val = K_PAR2; end
         default: begin f_val = b_ff ^ c_ff ^ d_ff;                          k_val = K_PAR2; end
      endcase
   end

   assign t_val = {a_ff[26:0], a_ff[31:27]} + f_val + e_ff + k_val + w_cur;

   always_comb begin
      blk_in = blk_ff;
      a_in   = a_ff;
      b_in   = b_ff;
      c_in   = c_ff;
      d_in   = d_ff;
      e_in   = e_ff;
      h_in   = h_ff;
      len_in = len_ff;

      if (cmd.push) begin
         blk_in = {blk_ff[503:0], push_byte};
      end else if (cmd.round) begin
         blk_in = {blk_ff[479:0], w_new};
      end

      if (cmd.len_inc) begin
         len_in = len_ff + LEN_W'(1);
      end

      if (cmd.load_work) begin
         a_in = h_ff[0];
         b_in = h_ff[1];
         c_in = h_ff[2];
         d_in = h_ff[3];
         e_in = h_ff[4];
      end else if (cmd.round) begin
         a_in = t_val;
         b_in = a_ff;
         c_in = {b_ff[1:0], b_ff[31:2]};
         d_in = c_ff;
         e_in = d_ff;
      end

      if (cmd.fold) begin
         h_in[0] = h_ff[0] + a_ff;
         h_in[1] = h_ff[1] + b_ff;
         h_in[2] = h_ff[2] + c_ff;
         h_in[3] = h_ff[3] + d_ff;
         h_in[4] = h_ff[4] + e_ff;
      end

      if (cmd.clear) begin
         h_in   = INIT_CHAIN;
         len_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         h_ff   <= INIT_CHAIN;
         len_ff <= '0;
      end else begin
         h_ff   <= h_in;
         len_ff <= len_in;
      end
   end

   always_ff @(posedge clock) begin
      blk_ff <= blk_in;
      a_ff   <= a_in;
      b_ff   <= b_in;
      c_ff   <= c_in;
      d_ff   <= d_in;
      e_ff   <= e_in;
   end

   always_comb begin
      case (cmd.word_sel)
         3'd0:    digest_word = h_ff[0];
         3'd1:    digest_word = h_ff[1];
         3'd2:    digest_word = h_ff[2];
         3'd3:    digest_word = h_ff[3];
         3'd4:    digest_word = h_ff[4];
         default: digest_word = h_ff[4];
      endcase
   end

endmodule

@@ rtl/core/sha1sh_ctrl.sv @@
// SHA-1 sequencer: fill count, padding steps, round counter and digest readout.
// Depends on sha1sh_pkg; issues commands to sha1sh_dp.
module sha1sh_ctrl (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   input  logic                       req_action,
   output logic                       req_ready,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic                       rsp_last,
   output logic [2:0]                 rsp_index,
   output sha1sh_pkg::sha1sh_cmd_type cmd
);
   import sha1sh_pkg::*;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_ROUND = 3'd1;
   localparam logic [2:0] S_FOLD  = 3'd2;
   localparam logic [2:0] S_PADZ  = 3'd3;
   localparam logic [2:0] S_PADL  = 3'd4;
   localparam logic [2:0] S_OUT   = 3'd5;

   localparam logic [6:0] LAST_ROUND = 7'd79;
   localparam logic [2:0] LAST_WORD  = 3'd4;
   localparam logic [5:0] LAST_BYTE  = 6'd63;

   logic [2:0] state_ff, state_in;
   logic [2:0] ret_ff, ret_in;       // where to go after the fold
   logic [5:0] fill_ff, fill_in;
   logic [6:0] rnd_ff, rnd_in;
   logic [2:0] idx_ff, idx_in;

   always_comb begin
      state_in = state_ff;
      ret_in   = ret_ff;
      fill_in  = fill_ff;
      rnd_in   = rnd_ff;
      idx_in   = idx_ff;
      cmd      = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;

      cmd.len_sel  = fill_ff[2:0];
      cmd.word_sel = idx_ff;
      if (rnd_ff < 7'd20)      cmd.phase = PH_CH;
      else if (rnd_ff < 7'd40) cmd.phase = PH_PAR1;
      else if (rnd_ff < 7'd60) cmd.phase = PH_MAJ;
      else                     cmd.phase = PH_PAR2;

      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.push = 1'b1;
               fill_in  = fill_ff + 6'd1;
               if (req_action == ACT_FINISH) begin
                  cmd.byte_src = SRC_PAD;
                  ret_in       = S_PADZ;
               end else begin
                  cmd.byte_src = SRC_DATA;
                  cmd.len_inc  = 1'b1;
                  ret_in       = S_IDLE;
               end
               if (fill_ff == LAST_BYTE) begin
                  cmd.load_work = 1'b1;
                  rnd_in        = '0;
                  state_in      = S_ROUND;
               end else begin
                  state_in = ret_in;
               end
            end
         end
         S_ROUND: begin
            cmd.round = 1'b1;
            rnd_in    = rnd_ff + 7'd1;
            if (rnd_ff == LAST_ROUND) begin
               state_in = S_FOLD;
            end
         end
         S_FOLD: begin
            cmd.fold = 1'b1;
            state_in = ret_ff;
         end
         S_PADZ: begin
            cmd.push = 1'b1;
            fill_in  = fill_ff + 6'd1;
            if (fill_ff == LEN_START) begin
               cmd.byte_src = SRC_LEN;
               state_in     = S_PADL;
            end else begin
               cmd.byte_src = SRC_ZERO;
               if (fill_ff == LAST_BYTE) begin
                  cmd.load_work = 1'b1;
                  rnd_in        = '0;
                  ret_in        = S_PADZ;
                  state_in      = S_ROUND;
               end
            end
         end
         S_PADL: begin
            cmd.push     = 1'b1;
            cmd.byte_src = SRC_LEN;
            fill_in      = fill_ff + 6'd1;
            if (fill_ff == LAST_BYTE) begin
               cmd.load_work = 1'b1;
               rnd_in        = '0;
               ret_in        = S_OUT;
               state_in      = S_ROUND;
            end
         end
         S_OUT: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               if (idx_ff == LAST_WORD) begin
                  cmd.clear = 1'b1;
                  idx_in    = '0;
                  state_in  = S_IDLE;
               end else begin
                  idx_in = idx_ff + 3'd1;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign rsp_last  = (idx_ff == LAST_WORD);
   assign rsp_index = idx_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         ret_ff   <= S_IDLE;
         fill_ff  <= '0;
         rnd_ff   <= '0;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         ret_ff   <= ret_in;
         fill_ff  <= fill_in;
         rnd_ff   <= rnd_in;
         idx_ff   <= idx_in;
      end
   end

endmodule

@@ rtl/core/sha1_stream_hasher_unit.sv @@
// SHA-1 stream hasher top level: byte stream in, five digest words out.
// Depends on sha1sh_pkg, sha1sh_ctrl and sha1sh_dp.
//
//   channel  | dir | payload                              | sideband
//   ---------+-----+--------------------------------------+---------------------------
//   req_     | in  | tdata[7:0] message byte              | tuser[0] 0=absorb 1=finish
//   rsp_     | out | tdata[31:0] digest word, big-endian  | tuser[2:0] word index, tlast
//
// Every 64th absorb byte starts a compression (80 rounds at one round per
// cycle, then the chaining add). A finish pushes 9 to 72 padding bytes at
// one per cycle outside compression, with one or two compressions, then
// presents the five digest words, one per rsp transfer. req_tready is low
// while compressing, padding or presenting the digest; rsp_tready low simply
// holds the current word. Reset is synchronous and returns the initial
// chaining words, zero length and an empty buffer.
module sha1_stream_hasher_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic [0:0]  req_tuser,   // [0] action
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [31:0] digest_word
   output logic [2:0]  rsp_tuser,   // [2:0] word_index
   output logic        rsp_tlast
);
   import sha1sh_pkg::*;

   sha1sh_cmd_type cmd;

   sha1sh_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_tvalid),
      .req_action (req_tuser[0]),
      .req_ready  (req_tready),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp_last   (rsp_tlast),
      .rsp_index  (rsp_tuser),
      .cmd        (cmd)
   );

   sha1sh_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .data_byte   (req_tdata),
      .digest_word (rsp_tdata)
   );

endmodule
